// ----- design/mfmf_pkg.sv -----
// ----------------------------------------------------------------------------
// mfmf_pkg: shared types and constants of the first-minimum finder
// Beat structs, register indexes, sequencer states and fixed-point limits.
// ----------------------------------------------------------------------------
package mfmf_pkg;

    localparam int IN_W   = 16;   // Q2.14 input parts
    localparam int POS_W  = 32;   // Q8.24 positions
    localparam int MOD_W  = 30;   // Q2.28 squared modulus
    localparam int CFG_W  = 32;   // widest configuration register
    localparam int ACC_W  = 32;   // sum of two squares before limiting
    localparam int DIV_W  = 63;   // magnitude of the interpolation numerator
    localparam int DSR_W  = 32;   // magnitude of the denominator
    localparam int STEP_W = 6;    // divider step counter

    localparam logic [MOD_W-1:0] MOD_ONE   = MOD_W'(1) << 28;
    localparam logic [ACC_W-1:0] MOD_LIMIT = ACC_W'(3) << 28;

    localparam logic [CFG_W-1:0] FIRST_CENTER_RST = '0;
    localparam logic [CFG_W-1:0] BIN_WIDTH_RST    = CFG_W'(33554);

    // register indexes on the configuration port
    localparam logic CFG_FIRST_CENTER = 1'b0;
    localparam logic CFG_BIN_WIDTH    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_CHECK,
        ST_MUL_X,
        ST_MUL_N,
        ST_ABS,
        ST_DIV,
        ST_ADJ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [IN_W-1:0] re_part;
        logic signed [IN_W-1:0] im_part;
        logic                   last_bin;
    } in_beat_t;

    typedef struct packed {
        logic signed [POS_W-1:0] root_pos;
        logic                    found;
    } out_beat_t;

endpackage

// ----- design/modulus_first_minimum_finder.sv -----
// Sequencing: an accepted bin runs through SQ_RE, SQ_IM, CHECK and DONE before the
// block is ready again, and a last bin shows its result from DONE once the output is
// free. A bin that locks a minimum adds two multiplies, a sign step, 63 divide steps
// and a final add, or skips the divide when the denominator is zero. No new bin is
// taken until the last is done; the shared 33x33 multiplier forms both squares in turn.
// Reset: synchronous aresetn clears window, count, lock and valid; registers go to defaults.
// ----------------------------------------------------------------------------
// modulus_first_minimum_finder: streaming first-minimum finder
// Forms the squared modulus of each bin, finds the first local minimum below
// one and reports its parabolic-interpolated position at the last bin.
// ----------------------------------------------------------------------------
module modulus_first_minimum_finder
    import mfmf_pkg::*;
#(
    parameter int MAX_BINS = 4096
) (
    input  logic             aclk,
    input  logic             aresetn,
    // configuration write port
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    // bin input
    input  logic             s_valid,
    output logic             s_ready,
    input  in_beat_t         s_data,
    // result output
    output logic             m_valid,
    input  logic             m_ready,
    output out_beat_t        m_data
);

    localparam int CNT_W  = $clog2(MAX_BINS + 1);
    localparam int X_W    = CNT_W + 33;
    localparam int WIDE_W = 65;
    localparam int MUL_W  = 33;

    localparam logic signed [WIDE_W-1:0] POS_MAX = WIDE_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [WIDE_W-1:0] POS_MIN = -WIDE_W'(64'sh0000_0000_8000_0000);

    // configuration
    logic [CFG_W-1:0] fc_reg;
    logic [CFG_W-1:0] bw_reg;

    // sequencer and stream state
    state_t                  state_reg,  state_next;
    logic [MOD_W-1:0]        win_reg [3];
    logic [MOD_W-1:0]        win_next [3];
    logic [CNT_W-1:0]        cnt_reg,    cnt_next;
    logic                    locked_reg, locked_next;
    logic                    m_valid_reg, m_valid_next;

    // datapath
    in_beat_t                in_reg,     in_next;
    logic [ACC_W-1:0]        acc_reg,    acc_next;
    logic [MOD_W-1:0]        mod_reg,    mod_next;
    logic [X_W-1:0]          x0_reg,     x0_next;
    logic signed [63:0]      num_reg,    num_next;
    logic signed [32:0]      den_reg,    den_next;
    logic [DIV_W-1:0]        dvd_reg,    dvd_next;
    logic [DSR_W-1:0]        rem_reg,    rem_next;
    logic [DSR_W-1:0]        dsr_reg,    dsr_next;
    logic                    neg_reg,    neg_next;
    logic [STEP_W-1:0]       step_reg,   step_next;
    logic [POS_W-1:0]        held_reg,   held_next;
    out_beat_t               out_reg,    out_next;

    // shared multiplier
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [2*MUL_W-1:0] mul_p;

    // helpers
    logic [MOD_W-1:0]        mod_now;
    logic signed [30:0]      diff_now;
    logic signed [32:0]      half_den;
    logic signed [32:0]      den_now;
    logic                    cand;
    logic [DSR_W+1:0]        trial;
    logic [63:0]             num_abs;
    logic [32:0]             den_abs;
    logic signed [WIDE_W-1:0] pos_wide;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fc_reg <= FIRST_CENTER_RST;
            bw_reg <= BIN_WIDTH_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FIRST_CENTER: fc_reg <= cfg_wdata;
                CFG_BIN_WIDTH:    bw_reg <= cfg_wdata;
                default:          fc_reg <= fc_reg;
            endcase
        end
    end

    // Select multiplier operands by step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQ_RE: begin
                mul_a = MUL_W'(in_reg.re_part);
                mul_b = MUL_W'(in_reg.re_part);
            end
            ST_SQ_IM: begin
                mul_a = MUL_W'(in_reg.im_part);
                mul_b = MUL_W'(in_reg.im_part);
            end
            ST_MUL_X: begin
                mul_a = $signed(MUL_W'(cnt_reg - CNT_W'(2)));
                mul_b = $signed({1'b0, bw_reg});
            end
            ST_MUL_N: begin
                mul_a = $signed({1'b0, bw_reg});
                mul_b = MUL_W'(diff_now);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Limit the modulus and evaluate the candidate
    assign mod_now  = (acc_reg > MOD_LIMIT) ? '0 : acc_reg[MOD_W-1:0];
    assign diff_now = $signed({1'b0, win_reg[0]}) - $signed({1'b0, win_reg[2]});
    assign half_den = $signed({2'b00, win_reg[1], 1'b0})
                    - $signed({3'b000, win_reg[0]})
                    - $signed({3'b000, win_reg[2]});
    assign den_now  = {half_den[31:0], 1'b0};
    assign cand     = !locked_reg
                   && (cnt_reg >= CNT_W'(3))
                   && (cnt_reg <= CNT_W'(MAX_BINS - 1))
                   && (win_reg[2] > win_reg[1])
                   && (mod_now > win_reg[1])
                   && (win_reg[1] < MOD_ONE);

    // Restoring divide step, magnitudes and final position
    assign trial    = {1'b0, rem_reg, dvd_reg[DIV_W-1]} - {2'b00, dsr_reg};
    assign num_abs  = num_reg[63] ? 64'(-num_reg) : 64'(num_reg);
    assign den_abs  = den_reg[32] ? 33'(-den_reg) : 33'(den_reg);
    assign pos_wide = neg_reg ? $signed(WIDE_W'(x0_reg)) + $signed(WIDE_W'(dvd_reg))
                              : $signed(WIDE_W'(x0_reg)) - $signed(WIDE_W'(dvd_reg));

    // Next state and datapath
    always_comb begin
        state_next   = state_reg;
        win_next     = win_reg;
        cnt_next     = cnt_reg;
        locked_next  = locked_reg;
        m_valid_next = m_valid_reg && !m_ready;
        in_next      = in_reg;
        acc_next     = acc_reg;
        mod_next     = mod_reg;
        x0_next      = x0_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        dsr_next     = dsr_reg;
        neg_next     = neg_reg;
        step_next    = step_reg;
        held_next    = held_reg;
        out_next     = out_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = ST_SQ_RE;
                end
            end
            ST_SQ_RE: begin
                acc_next   = mul_p[ACC_W-1:0];
                state_next = ST_SQ_IM;
            end
            ST_SQ_IM: begin
                acc_next   = acc_reg + mul_p[ACC_W-1:0];
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                mod_next   = mod_now;
                den_next   = den_now;
                state_next = cand ? ST_MUL_X : ST_DONE;
            end
            ST_MUL_X: begin
                // bin centre: first_center + (b-1) * width
                x0_next    = X_W'(fc_reg) + mul_p[X_W-1:0];
                state_next = ST_MUL_N;
            end
            ST_MUL_N: begin
                num_next   = mul_p[63:0];
                state_next = ST_ABS;
            end
            ST_ABS: begin
                neg_next  = num_reg[63] ^ den_reg[32];
                dsr_next  = den_abs[DSR_W-1:0];
                rem_next  = '0;
                step_next = '0;
                if (den_reg == '0) begin
                    // flat parabola: hold the bin centre
                    dvd_next   = '0;
                    state_next = ST_ADJ;
                end else begin
                    dvd_next   = num_abs[DIV_W-1:0];
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!trial[DSR_W+1]) begin
                    rem_next = trial[DSR_W-1:0];
                    dvd_next = {dvd_reg[DIV_W-2:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[DSR_W-2:0], dvd_reg[DIV_W-1]};
                    dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_W - 1)) begin
                    state_next = ST_ADJ;
                end
            end
            ST_ADJ: begin
                // saturate to the signed position range and lock
                if (pos_wide > POS_MAX) begin
                    held_next = POS_MAX[POS_W-1:0];
                end else if (pos_wide < POS_MIN) begin
                    held_next = POS_MIN[POS_W-1:0];
                end else begin
                    held_next = pos_wide[POS_W-1:0];
                end
                locked_next = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (!in_reg.last_bin) begin
                    // advance the window and the bin count
                    win_next[0] = win_reg[1];
                    win_next[1] = win_reg[2];
                    win_next[2] = mod_reg;
                    if (cnt_reg < CNT_W'(MAX_BINS)) begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    // emit the result beat and start a new histogram
                    out_next.root_pos = locked_reg ? $signed(held_reg) : '0;
                    out_next.found    = locked_reg;
                    m_valid_next      = 1'b1;
                    win_next[0]       = '0;
                    win_next[1]       = '0;
                    win_next[2]       = '0;
                    cnt_next          = '0;
                    locked_next       = 1'b0;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and stream state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            win_reg[0]  <= '0;
            win_reg[1]  <= '0;
            win_reg[2]  <= '0;
            cnt_reg     <= '0;
            locked_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            win_reg     <= win_next;
            cnt_reg     <= cnt_next;
            locked_reg  <= locked_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        in_reg   <= in_next;
        acc_reg  <= acc_next;
        mod_reg  <= mod_next;
        x0_reg   <= x0_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        neg_reg  <= neg_next;
        step_reg <= step_next;
        held_reg <= held_next;
        out_reg  <= out_next;
    end

endmodule

// ----- design/mfmf_chk.sv -----
// ----------------------------------------------------------------------------
// mfmf_chk: port checker for the first-minimum finder
// Watches the bin and result channels of the top level over time.
// ----------------------------------------------------------------------------
module mfmf_chk
    import mfmf_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_beat_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // no minimum means a zero position
    a_zero_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.root_pos == '0)
        else $error("position not zero without a found minimum");

    // an accepted bin keeps the block busy for the next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("bin accepted while previous still in work");

    // a new result appears only as the block goes idle
    a_rise_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result raised while block busy");

    // reset drops the result valid
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind modulus_first_minimum_finder mfmf_chk u_mfmf_chk (.*);

// ----- sim/mfmf_position_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mfmf_position_checker: result predictor and scoreboard of the finder
// Watches the register port and both channels, predicts the interpolated
// minimum position of every histogram and compares it with each result beat.
// ----------------------------------------------------------------------------
module mfmf_position_checker
    import mfmf_pkg::*;
#(
    parameter int MAX_BINS = 4096
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_valid,
    input  logic             s_ready,
    input  in_beat_t         s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  out_beat_t        m_data,
    output int               fail_count,
    output int               pending,
    output int               result_count,
    output int               found_count
);

    // predictor copy of registers and stream state
    logic [CFG_W-1:0] center_reg;
    logic [CFG_W-1:0] width_reg;
    logic [MOD_W-1:0] mod_window [3];
    int               bins_in_hist;
    logic             min_held;
    logic [POS_W-1:0] held_root;

    out_beat_t        expected_roots [$];

    initial begin
        fail_count   = 0;
        pending      = 0;
        result_count = 0;
        found_count  = 0;
    end

    function automatic logic [POS_W-1:0] clamp_pos(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[POS_W-1:0];
    endfunction

    always @(posedge aclk) begin : predict_and_compare
        longint    re_v, im_v, sq;
        longint    gl, g0, gn, w, x0, den, pos;
        int        k;
        out_beat_t want;
        out_beat_t got;

        if (!aresetn) begin
            // return to reset defaults, drop anything outstanding
            center_reg   = FIRST_CENTER_RST;
            width_reg    = BIN_WIDTH_RST;
            mod_window   = '{default: '0};
            bins_in_hist = 0;
            min_held     = 1'b0;
            held_root    = '0;
            expected_roots.delete();
        end else begin
            // track register writes
            if (cfg_we) begin
                if (cfg_index == CFG_FIRST_CENTER)
                    center_reg = cfg_wdata;
                else if (cfg_index == CFG_BIN_WIDTH)
                    width_reg = cfg_wdata;
            end

            // advance the prediction on every accepted bin beat
            if (s_valid && s_ready) begin
                re_v = longint'($signed(s_data.re_part));
                im_v = longint'($signed(s_data.im_part));
                sq   = re_v * re_v + im_v * im_v;
                if (sq > longint'(MOD_LIMIT))
                    sq = 0;

                k = bins_in_hist + 1;
                if (!min_held && k >= 4 && k <= MAX_BINS) begin
                    gl = longint'(mod_window[0]);
                    g0 = longint'(mod_window[1]);
                    gn = longint'(mod_window[2]);
                    // candidate is bin k-2: both followers strictly larger, below one
                    if (gn > g0 && sq > g0 && g0 < longint'(MOD_ONE)) begin
                        w   = longint'(width_reg);
                        x0  = longint'(center_reg) + longint'(k - 3) * w;
                        den = 2 * (2 * g0 - gl - gn);
                        pos = x0;
                        if (den != 0)
                            pos = x0 - (w * (gl - gn)) / den;
                        held_root = clamp_pos(pos);
                        min_held  = 1'b1;
                    end
                end

                mod_window[0] = mod_window[1];
                mod_window[1] = mod_window[2];
                mod_window[2] = sq[MOD_W-1:0];
                if (bins_in_hist < MAX_BINS)
                    bins_in_hist++;

                // close the histogram on its last bin
                if (s_data.last_bin) begin
                    want.root_pos = min_held ? held_root : '0;
                    want.found    = min_held;
                    expected_roots.push_back(want);
                    mod_window   = '{default: '0};
                    bins_in_hist = 0;
                    min_held     = 1'b0;
                    held_root    = '0;
                end
            end

            // compare each result beat against the oldest prediction
            if (m_valid && m_ready) begin
                got = m_data;
                result_count++;
                if (got.found)
                    found_count++;
                if (expected_roots.size() == 0) begin
                    $error("result beat with nothing predicted: root_pos %0d found %0b",
                           $signed(got.root_pos), got.found);
                    fail_count++;
                end else begin
                    want = expected_roots.pop_front();
                    if (got.root_pos !== want.root_pos) begin
                        $error("root_pos: expected %0d, actual %0d",
                               $signed(want.root_pos), $signed(got.root_pos));
                        fail_count++;
                    end
                    if (got.found !== want.found) begin
                        $error("found: expected %0b, actual %0b", want.found, got.found);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_roots.size();
    end

endmodule

// ----- sim/modulus_first_minimum_finder_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modulus_first_minimum_finder_tb: stimulus and verdict for the finder
// Streams directed and randomized histograms under several bin grids with
// random gaps and output stalls; the position checker scores every result.
// ----------------------------------------------------------------------------
module modulus_first_minimum_finder_tb;
    import mfmf_pkg::*;

    localparam int MAX_BINS     = 4096;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 600;
    localparam int GAP_MAX      = 19;
    localparam int PHASE_BINS   = 145;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_we    = 1'b0;
    logic             cfg_index = CFG_FIRST_CENTER;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    in_beat_t         s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    out_beat_t        m_data;

    int fail_count;
    int pending;
    int result_count;
    int found_count;
    int cycle_count   = 0;
    int bins_sent     = 0;
    int settings_used = 0;
    bit no_idle       = 1'b0;
    bit hold_req      = 1'b0;

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    modulus_first_minimum_finder #(
        .MAX_BINS (MAX_BINS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    mfmf_position_checker #(
        .MAX_BINS (MAX_BINS)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count),
        .found_count  (found_count)
    );

    // abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random stall before each beat, one long hold on request
    initial begin : result_sink
        int stall;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else if (no_idle) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, GAP_MAX);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    function automatic in_beat_t bin_of(input int re, input int im, input logic last);
        in_beat_t beat;
        beat.re_part  = re[IN_W-1:0];
        beat.im_part  = im[IN_W-1:0];
        beat.last_bin = last;
        return beat;
    endfunction

    // bin whose modulus sits just above mag squared, random signs and axis
    function automatic in_beat_t shape_bin(input int mag, input logic last);
        int a, b;
        a = (mag > 32767) ? 32767 : mag;
        b = $urandom_range(0, a / 4);
        if ($urandom_range(0, 1))
            a = -a;
        if ($urandom_range(0, 1))
            b = -b;
        if ($urandom_range(0, 1))
            return bin_of(a, b, last);
        return bin_of(b, a, last);
    endfunction

    // offer one bin beat after a random gap, hold it until accepted
    task automatic send_bin(input in_beat_t beat);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        bins_sent++;
    endtask

    // drop valid, wait for every predicted result, then let the divider settle
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic load_config(input logic [CFG_W-1:0] center, input logic [CFG_W-1:0] width);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FIRST_CENTER;
        cfg_wdata <= center;
        @(posedge aclk);
        cfg_index <= CFG_BIN_WIDTH;
        cfg_wdata <= width;
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // valley-shaped histogram with random depth, slope and ripple
    task automatic send_histogram(input int len, input bit shaped);
        int dip, slope, base, spread, mag;
        dip    = $urandom_range(1, len);
        slope  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(200, 6000);
        base   = $urandom_range(0, 20000);
        spread = $urandom_range(0, 1) ? 0 : $urandom_range(0, 3000);
        for (int i = 1; i <= len; i++) begin
            mag = base + ((i > dip) ? i - dip : dip - i) * slope + $urandom_range(0, spread);
            if (!shaped || $urandom_range(0, 19) == 0)
                send_bin(bin_of($urandom_range(0, 65535), $urandom_range(0, 65535), i == len));
            else
                send_bin(shape_bin(mag, i == len));
        end
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] center, width;
        int               len, phase_bins;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: lone last bin, nothing found
        send_bin(bin_of(0, 0, 1'b1));
        // first bin never a candidate; oversized follower is forced to zero
        send_bin(bin_of(100, 0, 1'b0));
        send_bin(bin_of(12000, 0, 1'b0));
        send_bin(bin_of(20000, 0, 1'b0));
        send_bin(bin_of(-32768, 32767, 1'b1));
        // lock on bin 2, later bins ignored, extreme parts on the way
        send_bin(bin_of(20000, 0, 1'b0));
        send_bin(bin_of(0, 8000, 1'b0));
        send_bin(bin_of(-12000, 0, 1'b0));
        send_bin(bin_of(16000, -1, 1'b0));
        send_bin(bin_of(32767, -32768, 1'b0));
        send_bin(bin_of(-32768, 0, 1'b1));
        // modulus of exactly one does not qualify
        send_bin(bin_of(25000, 0, 1'b0));
        send_bin(bin_of(16384, 0, 1'b0));
        send_bin(bin_of(20000, 0, 1'b0));
        send_bin(bin_of(22000, 0, 1'b1));
        // zero denominator falls back to the bin centre
        send_bin(bin_of(0, 0, 1'b0));
        send_bin(bin_of(8000, 0, 1'b0));
        send_bin(bin_of(8000, 8000, 1'b0));
        send_bin(bin_of(12000, 0, 1'b1));
        // equal neighbor is not strictly larger
        send_bin(bin_of(20000, 0, 1'b0));
        send_bin(bin_of(5000, 0, 1'b0));
        send_bin(bin_of(5000, 0, 1'b0));
        send_bin(bin_of(9000, 0, 1'b0));
        send_bin(bin_of(0, 9000, 1'b1));
        drain_results();
        settings_used++;

        // random histograms under a range of bin grids
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin center = '0;           width = 32'd1;        end
                1: begin center = '1;           width = '1;           end
                2: begin center = 32'h8000_0000; width = '0;          end
                3: begin center = $urandom;     width = $urandom;     end
                4: begin center = 32'h0100_0000; width = $urandom_range(1, 1 << 20); end
                5: begin center = '0;           width = '1;           end
                6: begin center = '1;           width = 32'd1;        end
                default: begin
                    center = $urandom;
                    width  = $urandom_range(1, 1 << 26);
                end
            endcase
            load_config(center, width);
            phase_bins = 0;
            while (phase_bins < PHASE_BINS) begin
                case ($urandom_range(0, 19))
                    0, 1, 2:    len = $urandom_range(1, 2);
                    3, 4, 5:    len = $urandom_range(25, 60);
                    default:    len = $urandom_range(3, 24);
                endcase
                no_idle = ($urandom_range(0, 5) == 0);
                send_histogram(len, $urandom_range(0, 3) != 0);
                phase_bins += len;
            end
            no_idle = 1'b0;
            drain_results();
        end

        // hold the result side off while short histograms pile up behind it
        hold_req = 1'b1;
        no_idle  = 1'b1;
        for (int h = 0; h < 20; h++)
            send_histogram($urandom_range(2, 5), 1'b1);
        no_idle = 1'b0;
        drain_results();

        $display("Covered %0d bins in %0d histograms, %0d with a located minimum,",
                 bins_sent, result_count, found_count);
        $display("under %0d bin grids, with random gaps and a long stalled result side.",
                 settings_used);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
